// ===== hdl/tmms_pkg.sv =====
// ----------------------------------------------------------------------------
// tmms_pkg: shared types and constants of the trimmed min/max stabilizer
// Holds the frame job record, the back-end state codes, register indexes and
// the sizing defaults used by the top level.
// ----------------------------------------------------------------------------
package tmms_pkg;

    localparam int MAX_PIXELS_DEFAULT    = 32768;
    localparam int HISTORY_DEPTH_DEFAULT = 8;
    localparam int DEPTH_CAP             = 8;

    localparam logic [1:0] REG_LOW_OUTLIER  = 2'd0;
    localparam logic [1:0] REG_HIGH_OUTLIER = 2'd1;
    localparam logic [1:0] REG_AVG_DEPTH    = 2'd2;

    typedef struct packed {
        logic [15:0] cap_high;
        logic [15:0] cap_low;
    } job_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_DONE
    } back_state_t;

endpackage

// ===== hdl/tmms_front.sv =====
// ----------------------------------------------------------------------------
// tmms_front: sample intake and trimmed index capture
// Tracks the position within the frame, captures the samples at the low and
// high trimmed indexes and posts one job per frame on the last sample.
// ----------------------------------------------------------------------------
module tmms_front #(
    parameter int MAX_PIXELS = tmms_pkg::MAX_PIXELS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          low_cnt,
    input  logic [7:0]          high_cnt,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [15:0]         sample,
    input  logic [15:0]         frame_length,
    input  logic                last,
    output logic                job_valid,
    input  logic                job_ready,
    output tmms_pkg::job_t      job
);

    localparam int POS_W = $clog2(MAX_PIXELS);
    localparam logic [16:0] MAX_LEN = 17'(MAX_PIXELS);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_PIXELS - 1);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      cap_low_reg, cap_low_next;
    logic [15:0]      cap_high_reg, cap_high_next;

    logic [16:0] len_raw;
    logic [16:0] len;
    logic [16:0] low_ext;
    logic [16:0] high_ext;
    logic [16:0] low_idx;
    logic [16:0] high_idx;
    logic [16:0] pos_ext;
    logic        accept;

    assign in_ready = job_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        len_raw = {1'b0, frame_length};
        if (len_raw == 17'd0)
        begin
            len = 17'd1;
        end
        else if (len_raw > MAX_LEN)
        begin
            len = MAX_LEN;
        end
        else
        begin
            len = len_raw;
        end

        low_ext  = 17'(low_cnt);
        high_ext = 17'(high_cnt);
        low_idx  = (low_ext < len) ? low_ext : 17'd0;
        high_idx = ((high_ext + 17'd1) < len) ? (len - 17'd1 - high_ext) : (len - 17'd1);
        pos_ext  = 17'(pos_reg);

        cap_low_next  = cap_low_reg;
        cap_high_next = cap_high_reg;
        pos_next      = pos_reg;
        if (accept)
        begin
            if (pos_ext == low_idx)
            begin
                cap_low_next = sample;
            end
            if ((pos_ext == high_idx) || (last && (pos_ext < high_idx)))
            begin
                cap_high_next = sample;
            end
            if (last || (pos_reg == POS_LAST))
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    assign job_valid     = accept && last;
    assign job.cap_low   = cap_low_next;
    assign job.cap_high  = cap_high_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            cap_low_reg  <= '0;
            cap_high_reg <= '0;
        end
        else
        begin
            pos_reg      <= pos_next;
            cap_low_reg  <= cap_low_next;
            cap_high_reg <= cap_high_next;
        end
    end

endmodule

// ===== hdl/tmms_queue.sv =====
// ----------------------------------------------------------------------------
// tmms_queue: two-entry job queue
// Decouples the sample intake from the averaging back end.
// ----------------------------------------------------------------------------
module tmms_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  tmms_pkg::job_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output tmms_pkg::job_t pop_data
);

    tmms_pkg::job_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           do_push;
    logic           do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/tmms_back.sv =====
// ----------------------------------------------------------------------------
// tmms_back: rolling history, averaging and result register
// Unless the depth is zero, pushes each frame's captures into the histories,
// sums the filled entries one per cycle and divides both sums by the entry
// count bit-serially; it then presents the result on the output register.
// ----------------------------------------------------------------------------
module tmms_back #(
    parameter int HISTORY_DEPTH = tmms_pkg::HISTORY_DEPTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           clear,
    input  logic [3:0]     depth_cfg,
    input  logic           job_valid,
    output logic           job_ready,
    input  tmms_pkg::job_t job,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [31:0]    out_data
);

    localparam int CNT_W     = $clog2(HISTORY_DEPTH + 1);
    localparam int IDX_W     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SUM_W     = 16 + CNT_W;
    localparam int STEP_W    = $clog2(SUM_W + 1);
    localparam int DEPTH_LIM = (tmms_pkg::DEPTH_CAP < HISTORY_DEPTH) ?
                               tmms_pkg::DEPTH_CAP : HISTORY_DEPTH;

    tmms_pkg::back_state_t state_reg, state_next;

    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic              full_reg, full_next;
    logic              out_valid_reg, out_valid_next;
    logic [31:0]       out_data_reg;

    logic [15:0]       hist_lo [HISTORY_DEPTH];
    logic [15:0]       hist_hi [HISTORY_DEPTH];

    logic [SUM_W-1:0]  acc_lo_reg;
    logic [SUM_W-1:0]  acc_hi_reg;
    logic [CNT_W-1:0]  rem_lo_reg;
    logic [CNT_W-1:0]  rem_hi_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  iter_reg;
    logic [STEP_W-1:0] step_reg;

    logic [CNT_W-1:0]  depth;
    logic              smooth;
    logic [IDX_W-1:0]  slot_use;
    logic [CNT_W-1:0]  slot_inc;
    logic [CNT_W-1:0]  count;
    logic              take;
    logic              sum_last;
    logic              div_last;
    logic              load_out;
    logic [CNT_W:0]    trial_lo;
    logic [CNT_W:0]    trial_hi;
    logic              ge_lo;
    logic              ge_hi;

    always_comb
    begin
        depth    = ({1'b0, depth_cfg} > 5'(DEPTH_LIM)) ? CNT_W'(DEPTH_LIM) : CNT_W'(depth_cfg);
        smooth   = (depth != '0);
        slot_use = (CNT_W'(slot_reg) >= depth) ? '0 : slot_reg;
        slot_inc = CNT_W'(slot_use) + CNT_W'(1);
        count    = full_reg ? depth : slot_inc;
        sum_last = ((iter_reg + CNT_W'(1)) == cnt_reg);
        div_last = (step_reg == STEP_W'(SUM_W - 1));
        trial_lo = {rem_lo_reg, acc_lo_reg[SUM_W-1]};
        trial_hi = {rem_hi_reg, acc_hi_reg[SUM_W-1]};
        ge_lo    = (trial_lo >= {1'b0, cnt_reg});
        ge_hi    = (trial_hi >= {1'b0, cnt_reg});
    end

    assign job_ready = (state_reg == tmms_pkg::ST_IDLE);
    assign take      = job_valid && job_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next = state_reg;
        load_out   = 1'b0;
        unique case (state_reg)
            tmms_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    state_next = smooth ? tmms_pkg::ST_SUM : tmms_pkg::ST_DONE;
                end
            end
            tmms_pkg::ST_SUM:
            begin
                if (sum_last)
                begin
                    state_next = tmms_pkg::ST_DIV;
                end
            end
            tmms_pkg::ST_DIV:
            begin
                if (div_last)
                begin
                    state_next = tmms_pkg::ST_DONE;
                end
            end
            tmms_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = tmms_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tmms_pkg::ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        slot_next = slot_reg;
        full_next = full_reg;
        if (clear)
        begin
            slot_next = '0;
            full_next = 1'b0;
        end
        else if (take && smooth)
        begin
            if (slot_inc >= depth)
            begin
                slot_next = '0;
                full_next = 1'b1;
            end
            else
            begin
                slot_next = slot_inc[IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && smooth)
        begin
            hist_lo[slot_use] <= job.cap_low;
            hist_hi[slot_use] <= job.cap_high;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            tmms_pkg::ST_IDLE:
            begin
                cnt_reg  <= count;
                iter_reg <= '0;
                if (smooth)
                begin
                    acc_lo_reg <= '0;
                    acc_hi_reg <= '0;
                end
                else
                begin
                    acc_lo_reg <= SUM_W'(job.cap_low);
                    acc_hi_reg <= SUM_W'(job.cap_high);
                end
            end
            tmms_pkg::ST_SUM:
            begin
                acc_lo_reg <= acc_lo_reg + SUM_W'(hist_lo[iter_reg[IDX_W-1:0]]);
                acc_hi_reg <= acc_hi_reg + SUM_W'(hist_hi[iter_reg[IDX_W-1:0]]);
                iter_reg   <= iter_reg + CNT_W'(1);
                rem_lo_reg <= '0;
                rem_hi_reg <= '0;
                step_reg   <= '0;
            end
            tmms_pkg::ST_DIV:
            begin
                rem_lo_reg <= ge_lo ? CNT_W'(trial_lo - {1'b0, cnt_reg}) : trial_lo[CNT_W-1:0];
                rem_hi_reg <= ge_hi ? CNT_W'(trial_hi - {1'b0, cnt_reg}) : trial_hi[CNT_W-1:0];
                acc_lo_reg <= {acc_lo_reg[SUM_W-2:0], ge_lo};
                acc_hi_reg <= {acc_hi_reg[SUM_W-2:0], ge_hi};
                step_reg   <= step_reg + STEP_W'(1);
            end
            tmms_pkg::ST_DONE:
            begin
                if (load_out)
                begin
                    out_data_reg <= {acc_hi_reg[15:0], acc_lo_reg[15:0]};
                end
            end
            default:
            begin
                iter_reg <= '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tmms_pkg::ST_IDLE;
            slot_reg      <= '0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> (slot_reg == '0) && !full_reg)
        else $error("history not cleared after register write");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tmms_pkg::ST_SUM) |-> (iter_reg < cnt_reg))
        else $error("history read beyond filled entries");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == tmms_pkg::ST_DONE))
        else $error("result presented without a finished job");
`endif

endmodule

// ===== hdl/trimmed_minmax_stabilizer_top.sv =====
// Throughput: one sample per cycle while the 2-job queue has room; the back end
// sums the history, then divides bit-serially when averaging, one job at a time.
// Reset: position, captures, history pointer and fill flag clear; histories empty.
// ----------------------------------------------------------------------------
// trimmed_minmax_stabilizer_top: trimmed frame min/max with rolling average
// Holds the configuration registers and joins the intake, queue and back end.
// ----------------------------------------------------------------------------
module trimmed_minmax_stabilizer_top #(
    parameter int MAX_PIXELS    = tmms_pkg::MAX_PIXELS_DEFAULT,
    parameter int HISTORY_DEPTH = tmms_pkg::HISTORY_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // sample[15:0], frame_length[31:16]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // stable_min[15:0], stable_max[31:16]
);

    logic [7:0] low_cnt_reg, low_cnt_next;
    logic [7:0] high_cnt_reg, high_cnt_next;
    logic [3:0] depth_reg, depth_next;
    logic       clear;

    tmms_pkg::job_t push_job;
    tmms_pkg::job_t pop_job;
    logic           push_valid;
    logic           push_ready;
    logic           pop_valid;
    logic           pop_ready;

    always_comb
    begin
        low_cnt_next  = low_cnt_reg;
        high_cnt_next = high_cnt_reg;
        depth_next    = depth_reg;
        clear         = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                tmms_pkg::REG_LOW_OUTLIER:
                begin
                    low_cnt_next = cfg_data;
                    clear        = 1'b1;
                end
                tmms_pkg::REG_HIGH_OUTLIER:
                begin
                    high_cnt_next = cfg_data;
                    clear         = 1'b1;
                end
                tmms_pkg::REG_AVG_DEPTH:
                begin
                    depth_next = cfg_data[3:0];
                    clear      = 1'b1;
                end
                default:
                begin
                    clear = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_cnt_reg  <= '0;
            high_cnt_reg <= '0;
            depth_reg    <= '0;
        end
        else
        begin
            low_cnt_reg  <= low_cnt_next;
            high_cnt_reg <= high_cnt_next;
            depth_reg    <= depth_next;
        end
    end

    tmms_front #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .low_cnt      (low_cnt_reg),
        .high_cnt     (high_cnt_reg),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .sample       (s_axis_tdata[15:0]),
        .frame_length (s_axis_tdata[31:16]),
        .last         (s_axis_tlast),
        .job_valid    (push_valid),
        .job_ready    (push_ready),
        .job          (push_job)
    );

    tmms_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_job)
    );

    tmms_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (clear),
        .depth_cfg (depth_reg),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job       (pop_job),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

// ===== test/trimmed_minmax_stabilizer_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trimmed_minmax_stabilizer_top_test: self-checking bench of the stabilizer
// Streams frames of samples with random idling on both sides. A directed table
// covers extremes, zero and oversized frame lengths, early last, depth limits
// and the unused register index. Random frames follow under random outlier
// counts and averaging depths. Each result is checked against a built-in
// prediction of the trimmed and averaged frame extent or a row's typed value.
// ----------------------------------------------------------------------------
module trimmed_minmax_stabilizer_top_test;

    localparam int MAX_PIX      = tmms_pkg::MAX_PIXELS_DEFAULT;
    localparam int HIST_DEPTH   = tmms_pkg::HISTORY_DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS = 1150;
    localparam int SETTLE       = 40;
    localparam int CYCLE_LIMIT  = 600000;

    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam logic [1:0] NO_IDX    = tmms_pkg::REG_LOW_OUTLIER;

    typedef struct packed {
        logic [15:0] hi;
        logic [15:0] lo;
    } extent_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  idx;
        logic [15:0] val;
        logic [15:0] flen;
        logic        lst;
        logic        typed;
        extent_t     want;
    } row_t;

    localparam extent_t NO_EXT = '0;

    localparam row_t DIRECTED [33] = '{
        '{ROW_ITEM, NO_IDX, 16'hFFFF, 16'd1,    1'b1, 1'b1, '{16'hFFFF, 16'hFFFF}},
        '{ROW_ITEM, NO_IDX, 16'h0000, 16'd0,    1'b1, 1'b1, '{16'h0000, 16'h0000}},
        '{ROW_ITEM, NO_IDX, 16'h0000, 16'd3,    1'b0, 1'b0, NO_EXT},
        '{ROW_ITEM, NO_IDX, 16'h1234, 16'd3,    1'b0, 1'b0, NO_EXT},
        '{ROW_ITEM, NO_IDX, 16'hFFFF, 16'd3,    1'b1, 1'b1, '{16'hFFFF, 16'h0000}},
        '{ROW_ITEM, NO_IDX, 16'h0007, 16'hFFFF, 1'b0, 1'b0, NO_EXT},
        '{ROW_ITEM, NO_IDX, 16'h0009, 16'hFFFF, 1'b1, 1'b1, '{16'h0009, 16'h0007}},
        '{ROW_CFG,  tmms_pkg::REG_LOW_OUTLIER,  16'h0001, 16'd0, 1'b0, 1'b0, NO_EXT},
        '{ROW_CFG,  tmms_pkg::REG_HIGH_OUTLIER, 16'h0001, 16'd0, 1'b0, 1'b0, NO_EXT},
        '{ROW_ITEM, NO_IDX, 16'h0001, 16'd4,    1'b0, 1'b0, NO_EXT},
        '{ROW_ITEM, NO_IDX, 16'h0002, 16'd4,    1'b0, 1'b0, NO_EXT},
        '{ROW_ITEM, NO_IDX, 16'h0003, 16'd4,    1'b0, 1'b0, NO_EXT},
        '{ROW_ITEM, NO_IDX, 16'h0004, 16'd4,    1'b1, 1'b1, '{16'h0003, 16'h0002}},
        '{ROW_CFG,  tmms_pkg::REG_LOW_OUTLIER,  16'h00FF, 16'd0, 1'b0, 1'b0, NO_EXT},
        '{ROW_ITEM, NO_IDX, 16'h0055, 16'd300,  1'b0, 1'b0, NO_EXT},
        '{ROW_ITEM, NO_IDX, 16'h0066, 16'd300,  1'b1, 1'b1, '{16'h0066, 16'h0002}},
        '{ROW_CFG,  tmms_pkg::REG_HIGH_OUTLIER, 16'h00FF, 16'd0, 1'b0, 1'b0, NO_EXT},
        '{ROW_ITEM, NO_IDX, 16'h8000, 16'd200,  1'b0, 1'b0, NO_EXT},
        '{ROW_ITEM, NO_IDX, 16'hAAAA, 16'd200,  1'b1, 1'b0, NO_EXT},
        '{ROW_CFG,  tmms_pkg::REG_LOW_OUTLIER,  16'h0000, 16'd0, 1'b0, 1'b0, NO_EXT},
        '{ROW_CFG,  tmms_pkg::REG_HIGH_OUTLIER, 16'h0000, 16'd0, 1'b0, 1'b0, NO_EXT},
        '{ROW_CFG,  tmms_pkg::REG_AVG_DEPTH,    16'h0002, 16'd0, 1'b0, 1'b0, NO_EXT},
        '{ROW_ITEM, NO_IDX, 16'h0064, 16'd1,    1'b1, 1'b1, '{16'h0064, 16'h0064}},
        '{ROW_ITEM, NO_IDX, 16'h00C8, 16'd1,    1'b1, 1'b1, '{16'h0096, 16'h0096}},
        '{ROW_ITEM, NO_IDX, 16'h0032, 16'd1,    1'b1, 1'b0, NO_EXT},
        '{ROW_CFG,  tmms_pkg::REG_AVG_DEPTH,    16'h000F, 16'd0, 1'b0, 1'b0, NO_EXT},
        '{ROW_ITEM, NO_IDX, 16'hFFFF, 16'd1,    1'b1, 1'b0, NO_EXT},
        '{ROW_ITEM, NO_IDX, 16'hFFFF, 16'd1,    1'b1, 1'b0, NO_EXT},
        '{ROW_CFG,  REG_SPARE,                  16'h00A5, 16'd0, 1'b0, 1'b0, NO_EXT},
        '{ROW_ITEM, NO_IDX, 16'h0001, 16'd1,    1'b1, 1'b0, NO_EXT},
        '{ROW_CFG,  tmms_pkg::REG_AVG_DEPTH,    16'h0008, 16'd0, 1'b0, 1'b0, NO_EXT},
        '{ROW_ITEM, NO_IDX, 16'hFFFF, 16'd2,    1'b0, 1'b0, NO_EXT},
        '{ROW_ITEM, NO_IDX, 16'hFFFF, 16'd2,    1'b1, 1'b0, NO_EXT}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = tmms_pkg::REG_LOW_OUTLIER;
    logic [7:0]  cfg_data = 8'h00;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = 32'h0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    // predicted block state
    int unsigned low_skip;
    int unsigned high_skip;
    int unsigned depth_reg;
    int unsigned position;
    logic [15:0] cap_lo;
    logic [15:0] cap_hi;
    logic [15:0] lo_hist [HIST_DEPTH];
    logic [15:0] hi_hist [HIST_DEPTH];
    int unsigned slot;
    bit          filled;

    extent_t     pending_extents [$];
    extent_t     want;
    bit          in_fire = 1'b0;
    bit          steady = 1'b0;
    int          errors = 0;
    int          cycles = 0;

    trimmed_minmax_stabilizer_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 23);
    end

    // sample both handshakes on the falling edge ahead of the edge that completes them
    always @(negedge clk)
    begin
        in_fire = rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_extents.size() == 0)
            begin
                errors++;
                $display("%0t: result %h with nothing expected", $time, m_axis_tdata);
            end
            else
            begin
                want = pending_extents.pop_front();
                if (m_axis_tdata[15:0] !== want.lo)
                begin
                    errors++;
                    $display("%0t: stable_min expected %h actual %h",
                             $time, want.lo, m_axis_tdata[15:0]);
                end
                if (m_axis_tdata[31:16] !== want.hi)
                begin
                    errors++;
                    $display("%0t: stable_max expected %h actual %h",
                             $time, want.hi, m_axis_tdata[31:16]);
                end
            end
        end
    end

    function automatic bit predict_extent(input logic [15:0] smp, input logic [15:0] flen,
                                          input bit lst, output extent_t res);
        int unsigned len;
        int unsigned lo_idx;
        int unsigned hi_idx;
        int unsigned d;
        int unsigned cnt;
        int unsigned sum_lo;
        int unsigned sum_hi;
        len = 32'(flen);
        if (len == 0)
            len = 1;
        if (len > MAX_PIX)
            len = MAX_PIX;
        lo_idx = (low_skip < len) ? low_skip : 0;
        hi_idx = (high_skip + 1 < len) ? (len - 1 - high_skip) : (len - 1);
        if (position == lo_idx)
            cap_lo = smp;
        if (position == hi_idx || (lst && position < hi_idx))
            cap_hi = smp;
        res = '0;
        if (!lst)
        begin
            position++;
            if (position >= MAX_PIX)
                position = 0;
            return 1'b0;
        end
        position = 0;
        res.lo = cap_lo;
        res.hi = cap_hi;
        d = depth_reg;
        if (d > tmms_pkg::DEPTH_CAP)
            d = tmms_pkg::DEPTH_CAP;
        if (d > HIST_DEPTH)
            d = HIST_DEPTH;
        if (d > 0)
        begin
            if (slot >= d)
                slot = 0;
            lo_hist[slot % HIST_DEPTH] = cap_lo;
            hi_hist[slot % HIST_DEPTH] = cap_hi;
            cnt = filled ? d : slot + 1;
            sum_lo = 0;
            sum_hi = 0;
            for (int i = 0; i < cnt && i < HIST_DEPTH; i++)
            begin
                sum_lo += lo_hist[i];
                sum_hi += hi_hist[i];
            end
            res.lo = 16'(sum_lo / cnt);
            res.hi = 16'(sum_hi / cnt);
            slot++;
            if (slot >= d)
            begin
                slot = 0;
                filled = 1'b1;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic [7:0] pick_skip();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 8'($urandom_range(0, 15));
        else if (r < 80)
            return 8'($urandom_range(16, 64));
        else if (r < 90)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx != REG_SPARE)
        begin
            if (idx == tmms_pkg::REG_LOW_OUTLIER)
                low_skip = 32'(val);
            else if (idx == tmms_pkg::REG_HIGH_OUTLIER)
                high_skip = 32'(val);
            else
                depth_reg = 32'(val[3:0]);
            slot = 0;
            filled = 1'b0;
        end
    endtask

    task automatic send_item(input logic [15:0] smp, input logic [15:0] flen, input bit lst,
                             input bit typed, input extent_t typed_val);
        extent_t got;
        while (!steady && $urandom_range(0, 99) < 23)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {flen, smp};
        s_axis_tlast <= lst;
        @(posedge clk);
        while (!in_fire)
            @(posedge clk);
        if (predict_extent(smp, flen, lst, got))
            pending_extents.push_back(typed ? typed_val : got);
    endtask

    // hold off until every result is out and the intake has settled
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        while (pending_extents.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        row_t        row;
        int          random_sent;
        int          nwrites;
        int          nframes;
        int          pick;
        int          r;
        int          count;
        logic [15:0] flen;

        low_skip = 0;
        high_skip = 0;
        depth_reg = 0;
        position = 0;
        cap_lo = '0;
        cap_hi = '0;
        slot = 0;
        filled = 1'b0;
        for (int i = 0; i < HIST_DEPTH; i++)
        begin
            lo_hist[i] = '0;
            hi_hist[i] = '0;
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (int n = 0; n < $size(DIRECTED); n++)
        begin
            row = DIRECTED[n];
            if (row.kind == ROW_CFG)
            begin
                drain_block();
                write_reg(row.idx, row.val[7:0]);
            end
            else
                send_item(row.val, row.flen, row.lst, row.typed, row.want);
        end

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            drain_block();
            nwrites = $urandom_range(1, 3);
            for (int w = 0; w < nwrites; w++)
            begin
                pick = $urandom_range(0, 11);
                if (pick == 0)
                    write_reg(REG_SPARE, 8'($urandom_range(0, 255)));
                else if (pick < 5)
                    write_reg(tmms_pkg::REG_LOW_OUTLIER, pick_skip());
                else if (pick < 9)
                    write_reg(tmms_pkg::REG_HIGH_OUTLIER, pick_skip());
                else
                begin
                    r = $urandom_range(0, 9);
                    if (r < 2)
                        write_reg(tmms_pkg::REG_AVG_DEPTH, 8'd0);
                    else if (r < 4)
                        write_reg(tmms_pkg::REG_AVG_DEPTH, 8'($urandom_range(9, 15)));
                    else
                        write_reg(tmms_pkg::REG_AVG_DEPTH, 8'($urandom_range(1, 8)));
                end
            end
            nframes = $urandom_range(4, 16);
            for (int f = 0; f < nframes; f++)
            begin
                steady = (random_sent >= 450 && random_sent < 750);
                r = $urandom_range(0, 99);
                if (r < 70)
                    flen = 16'($urandom_range(1, 12));
                else if (r < 85)
                    flen = 16'($urandom_range(13, 40));
                else if (r < 92)
                    flen = 16'd0;
                else
                    flen = 16'($urandom_range(32769, 65535));
                count = (flen == 16'd0) ? 1 : int'(flen);
                if (flen > 16'd40)
                    count = $urandom_range(1, 20);
                else if ($urandom_range(0, 99) < 15)
                    count = $urandom_range(1, count);
                for (int k = 0; k < count; k++)
                begin
                    send_item(16'($urandom_range(0, 65535)), flen, k == count - 1,
                              1'b0, NO_EXT);
                    random_sent++;
                end
            end
        end
        steady = 1'b0;

        drain_block();
        if (errors == 0 && pending_extents.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== trimmed_minmax_stabilizer_top.f =====
hdl/tmms_pkg.sv
hdl/tmms_front.sv
hdl/tmms_queue.sv
hdl/tmms_back.sv
hdl/trimmed_minmax_stabilizer_top.sv
test/trimmed_minmax_stabilizer_top_test.sv
